// ===== src/gmpt_pkg.sv =====
// ----------------------------------------------------------------------------
// gmpt_pkg
// shared constants and types of the grid max path traceback block
// ----------------------------------------------------------------------------
package gmpt_pkg;

    localparam int COST_BITS    = 16;
    localparam int SUM_BITS     = 22;
    localparam int DIM_BITS     = 6;
    localparam int APB_DW       = 32;
    localparam int APB_AW       = 3;
    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 32;

    // register indexes, taken from paddr[2]
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // result kinds and moves
    localparam logic KIND_TOTAL = 1'b0;
    localparam logic KIND_MOVE  = 1'b1;
    localparam logic MOVE_RIGHT = 1'b0;
    localparam logic MOVE_DOWN  = 1'b1;

    typedef logic signed [COST_BITS-1:0] t_cost;
    typedef logic signed [SUM_BITS-1:0]  t_sum;
    typedef logic [DIM_BITS-1:0]         t_dim;

endpackage

// ===== src/gmpt_if.sv =====
// ----------------------------------------------------------------------------
// gmpt_in_if / gmpt_out_if
// valid/ready channels for grid cells and for path results
// ----------------------------------------------------------------------------
interface gmpt_in_if;
    import gmpt_pkg::*;

    logic  valid;
    logic  ready;
    t_cost cell_cost;

    modport source (output valid, output cell_cost, input ready);
    modport sink   (input valid, input cell_cost, output ready);
endinterface

interface gmpt_out_if;
    import gmpt_pkg::*;

    logic valid;
    logic ready;
    logic result_kind;
    logic move_down;
    t_sum total_cost;
    logic last_result;

    modport source (output valid, output result_kind, output move_down,
                    output total_cost, output last_result, input ready);
    modport sink   (input valid, input result_kind, input move_down,
                    input total_cost, input last_result, output ready);
endinterface

// ===== src/grid_max_path_traceback_top.sv =====
// ----------------------------------------------------------------------------
// grid_max_path_traceback_top
// maximum-cost right/down path through a grid, with traceback of the moves
//
// Cells of a grid_rows by grid_cols grid arrive on i_cell_if in row-major
// order. Each cell is taken in its transfer, then handled in S_CELL by the
// shared add/compare unit, which updates the row buffer and stores one
// direction bit. i_cell_if.ready is low while in S_CELL.
// After the last cell the sequencer walks the direction memory back from the
// bottom-right corner; each move is a registered memory read (S_TRD), then a
// push onto the move stack (S_TST). It then sends the total cost, followed
// by the moves from the start, each by a stack read (S_MRD), then an output
// load (S_MOUT); the final result has last_result set. A stall on o_res_if
// holds the output register and stops the sequencer; the next run's cells
// are taken once the last result is loaded, even while it still waits.
// Reset sets both dimensions to 1 and starts a run at the top-left cell.
// Configuration is to be written over the APB port only while the block is
// idle; the block itself does not enforce this. A write while idle restarts
// the run.
// ----------------------------------------------------------------------------
module grid_max_path_traceback_top #(
    parameter int MAX_ROWS = gmpt_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gmpt_pkg::DEF_MAX_COLS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gmpt_pkg::APB_AW-1:0] paddr,
    input  logic [gmpt_pkg::APB_DW-1:0] pwdata,
    output logic [gmpt_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    gmpt_in_if.sink                     i_cell_if,
    gmpt_out_if.source                  o_res_if
);
    import gmpt_pkg::*;

    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int MOVES  = MAX_ROWS + MAX_COLS - 2;
    localparam int MW     = (MOVES > 0) ? $clog2(MOVES + 1) : 1;
    localparam int SDEPTH = (MOVES > 0) ? MOVES : 1;
    localparam int SW     = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int DIMW   = 10;
    localparam int FDEPTH = 2 ** (RW + CW);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CELL  = 3'd1;
    localparam logic [2:0] S_TRD   = 3'd2;
    localparam logic [2:0] S_TST   = 3'd3;
    localparam logic [2:0] S_TOTAL = 3'd4;
    localparam logic [2:0] S_MRD   = 3'd5;
    localparam logic [2:0] S_MOUT  = 3'd6;

    // configuration
    t_dim r_rows;
    t_dim r_cols;
    logic cfg_wr;

    // sequencer and datapath
    logic [2:0]    r_state, n_state;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_tr, n_tr;
    logic [CW-1:0] r_tc, n_tc;
    logic [MW-1:0] r_cnt, n_cnt;
    t_sum          r_left, n_left;
    t_sum          r_total, n_total;
    t_sum          r_up;
    t_cost         r_cost;
    logic          r_fa;
    logic          r_sdata;

    // output register
    logic r_ovalid, n_ovalid;
    logic r_okind, n_okind;
    logic r_omove, n_omove;
    t_sum r_ototal, n_ototal;
    logic r_olast, n_olast;

    // memories
    t_sum rs_mem [MAX_COLS];
    logic fa_mem [FDEPTH];
    logic st_mem [SDEPTH];

    logic [DIMW-1:0]     rows_ext, cols_ext, rows_eff, cols_eff;
    logic [RW-1:0]       row_last;
    logic [CW-1:0]       col_last;
    logic                in_xfer, out_free;
    logic                sel_up, first_cell, end_row, end_grid;
    t_sum                base, sum_sat;
    logic [SUM_BITS:0]   sum_w;
    logic                step_dir;
    logic [MW-1:0]       pop_idx;
    logic                rs_we, fa_we, st_we;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            CFG_ROWS: prdata = {{(APB_DW-DIM_BITS){1'b0}}, r_rows};
            CFG_COLS: prdata = {{(APB_DW-DIM_BITS){1'b0}}, r_cols};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= t_dim'(1);
            r_cols <= t_dim'(1);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                CFG_ROWS: r_rows <= pwdata[DIM_BITS-1:0];
                CFG_COLS: r_cols <= pwdata[DIM_BITS-1:0];
                default:  r_rows <= r_rows;
            endcase
        end
    end

    // dimensions in use
    always_comb begin
        rows_ext = DIMW'(r_rows);
        cols_ext = DIMW'(r_cols);
        if (rows_ext == '0) begin
            rows_eff = DIMW'(1);
        end else if (rows_ext > DIMW'(MAX_ROWS)) begin
            rows_eff = DIMW'(MAX_ROWS);
        end else begin
            rows_eff = rows_ext;
        end
        if (cols_ext == '0) begin
            cols_eff = DIMW'(1);
        end else if (cols_ext > DIMW'(MAX_COLS)) begin
            cols_eff = DIMW'(MAX_COLS);
        end else begin
            cols_eff = cols_ext;
        end
        row_last = RW'(rows_eff - DIMW'(1));
        col_last = CW'(cols_eff - DIMW'(1));
    end

    assign i_cell_if.ready = (r_state == S_IDLE);
    assign in_xfer         = i_cell_if.valid && i_cell_if.ready;
    assign out_free        = !r_ovalid || o_res_if.ready;

    // shared add/compare unit
    always_comb begin
        first_cell = (r_row == '0) && (r_col == '0);
        sel_up     = (r_row != '0) && ((r_col == '0) || (r_up >= r_left));
        if (first_cell) begin
            base = '0;
        end else if (sel_up) begin
            base = r_up;
        end else begin
            base = r_left;
        end
        sum_w = {base[SUM_BITS-1], base}
              + {{(SUM_BITS+1-COST_BITS){r_cost[COST_BITS-1]}}, r_cost};
        if (sum_w[SUM_BITS] != sum_w[SUM_BITS-1]) begin
            sum_sat = sum_w[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                      : {1'b0, {(SUM_BITS-1){1'b1}}};
        end else begin
            sum_sat = sum_w[SUM_BITS-1:0];
        end
        end_row  = (r_col == col_last);
        end_grid = end_row && (r_row == row_last);
        if (r_tc == '0) begin
            step_dir = MOVE_DOWN;
        end else if (r_tr == '0) begin
            step_dir = MOVE_RIGHT;
        end else begin
            step_dir = r_fa;
        end
        pop_idx = r_cnt - MW'(1);
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_col    = r_col;
        n_tr     = r_tr;
        n_tc     = r_tc;
        n_cnt    = r_cnt;
        n_left   = r_left;
        n_total  = r_total;
        n_ovalid = r_ovalid && !o_res_if.ready;
        n_okind  = r_okind;
        n_omove  = r_omove;
        n_ototal = r_ototal;
        n_olast  = r_olast;
        rs_we    = 1'b0;
        fa_we    = 1'b0;
        st_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (cfg_wr) begin
                    n_row  = '0;
                    n_col  = '0;
                    n_left = '0;
                    n_cnt  = '0;
                end else if (in_xfer) begin
                    n_state = S_CELL;
                end
            end
            S_CELL: begin
                rs_we = 1'b1;
                fa_we = 1'b1;
                if (end_grid) begin
                    n_row   = '0;
                    n_col   = '0;
                    n_left  = '0;
                    n_total = sum_sat;
                    n_tr    = row_last;
                    n_tc    = col_last;
                    n_cnt   = '0;
                    n_state = S_TRD;
                end else begin
                    n_left  = sum_sat;
                    n_state = S_IDLE;
                    if (end_row) begin
                        n_col = '0;
                        n_row = r_row + RW'(1);
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
            S_TRD: begin
                if ((r_tr == '0) && (r_tc == '0)) begin
                    n_state = S_TOTAL;
                end else begin
                    n_state = S_TST;
                end
            end
            S_TST: begin
                st_we   = 1'b1;
                n_cnt   = r_cnt + MW'(1);
                n_state = S_TRD;
                if (step_dir == MOVE_DOWN) begin
                    n_tr = r_tr - RW'(1);
                end else begin
                    n_tc = r_tc - CW'(1);
                end
            end
            S_TOTAL: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = KIND_TOTAL;
                    n_omove  = MOVE_RIGHT;
                    n_ototal = r_total;
                    n_olast  = (r_cnt == '0);
                    n_state  = (r_cnt == '0) ? S_IDLE : S_MRD;
                end
            end
            S_MRD: begin
                n_state = S_MOUT;
            end
            S_MOUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = KIND_MOVE;
                    n_omove  = r_sdata;
                    n_ototal = '0;
                    n_olast  = (r_cnt == MW'(1));
                    n_cnt    = pop_idx;
                    n_state  = (r_cnt == MW'(1)) ? S_IDLE : S_MRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_row    <= '0;
            r_col    <= '0;
            r_left   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_left   <= n_left;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tr     <= n_tr;
        r_tc     <= n_tc;
        r_total  <= n_total;
        r_okind  <= n_okind;
        r_omove  <= n_omove;
        r_ototal <= n_ototal;
        r_olast  <= n_olast;
        if (in_xfer) begin
            r_cost <= i_cell_if.cell_cost;
        end
    end

    // row buffer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_up <= rs_mem[r_col];
        end
        if (rs_we) begin
            rs_mem[r_col] <= sum_sat;
        end
    end

    // direction bits
    always_ff @(posedge i_clk) begin
        if (r_state == S_TRD) begin
            r_fa <= fa_mem[{r_tr, r_tc}];
        end
        if (fa_we) begin
            fa_mem[{r_row, r_col}] <= sel_up;
        end
    end

    // move stack
    always_ff @(posedge i_clk) begin
        if (r_state == S_MRD) begin
            r_sdata <= st_mem[pop_idx[SW-1:0]];
        end
        if (st_we) begin
            st_mem[r_cnt[SW-1:0]] <= step_dir;
        end
    end

    assign o_res_if.valid       = r_ovalid;
    assign o_res_if.result_kind = r_okind;
    assign o_res_if.move_down   = r_omove;
    assign o_res_if.total_cost  = r_ototal;
    assign o_res_if.last_result = r_olast;

    a_busy_after_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_cell_if.ready)
        else $error("cell taken while the previous one is still at work");

    a_move_no_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_okind == KIND_MOVE)) |-> (r_ototal == '0))
        else $error("move result carries a total cost");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TST) |-> (r_cnt < MW'(MOVES)))
        else $error("move stack overrun");

    a_total_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TOTAL) && out_free |=> r_ovalid && (r_okind == KIND_TOTAL))
        else $error("total cost result not loaded");

endmodule

// ===== test/grid_max_path_traceback_top_tb.sv =====
// ----------------------------------------------------------------------------
// grid_max_path_traceback_top_tb
// self-checking bench for the grid max path traceback block
//
// Grids of cell costs are streamed into the block in row-major order. A
// predictor in the bench keeps its own running best sums and direction bits.
// On the last cell of a grid it queues the expected total cost and the moves
// that follow it. Every result transfer is checked against the oldest entry
// of that queue. Directed grids cover cost extremes, the top row and the left
// column, ties, single cells, zero and oversize dimensions, and a restart in
// the middle of a grid. A 32 row column, a 32 column row and random small
// grids follow. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module grid_max_path_traceback_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gmpt_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_STALL     = 18;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 300;
    localparam int RANDOM_CELLS  = 30;
    localparam int SUM_HI        = 2 ** (SUM_BITS - 1) - 1;
    localparam int SUM_LO        = -(2 ** (SUM_BITS - 1));
    localparam t_cost COST_MIN   = {1'b1, {(COST_BITS - 1){1'b0}}};
    localparam t_cost COST_MAX   = {1'b0, {(COST_BITS - 1){1'b1}}};

    typedef enum int {COST_FULL, COST_TIES, COST_EXTREME} cost_mix_e;

    typedef struct packed {
        logic kind;
        logic move;
        t_sum total;
        logic last;
    } path_result_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    gmpt_in_if  cell_if ();
    gmpt_out_if res_if ();

    grid_max_path_traceback_top DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .i_cell_if (cell_if),
        .o_res_if  (res_if)
    );

    // predictor state
    t_dim rows_reg;
    t_dim cols_reg;
    t_sum col_best [DEF_MAX_COLS];
    t_sum left_best;
    bit   came_from_above [DEF_MAX_ROWS * DEF_MAX_COLS];
    int   row_pos;
    int   col_pos;

    path_result_t pending_results [$];

    int error_count  = 0;
    int cycle_count  = 0;
    int cells_sent   = 0;
    int results_seen = 0;
    int grids_done   = 0;
    int stall_left   = 0;
    bit sender_idle_on;
    bit receiver_idle_on;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int clamp_dim(t_dim value, int hi);
        if (value == 0)
            return 1;
        if (int'(value) > hi)
            return hi;
        return int'(value);
    endfunction

    function automatic void restart_grid();
        row_pos   = 0;
        col_pos   = 0;
        left_best = '0;
    endfunction

    function automatic void predict_cell(t_cost cost);
        int           rows;
        int           cols;
        int           r;
        int           c;
        int           s;
        int           tr;
        int           tc;
        bit           dir;
        bit           moves [$];
        path_result_t res;
        rows = clamp_dim(rows_reg, DEF_MAX_ROWS);
        cols = clamp_dim(cols_reg, DEF_MAX_COLS);
        r    = row_pos;
        c    = col_pos;
        dir  = MOVE_RIGHT;
        if (r == 0 && c == 0) begin
            s = cost;
        end else if (r == 0) begin
            s = left_best + cost;
        end else if (c == 0) begin
            s   = col_best[0] + cost;
            dir = MOVE_DOWN;
        end else if (col_best[c] >= left_best) begin
            // tie goes down
            s   = col_best[c] + cost;
            dir = MOVE_DOWN;
        end else begin
            s = left_best + cost;
        end
        if (s > SUM_HI)
            s = SUM_HI;
        if (s < SUM_LO)
            s = SUM_LO;
        col_best[c]                         = t_sum'(s);
        left_best                           = t_sum'(s);
        came_from_above[r * DEF_MAX_COLS + c] = dir;

        c++;
        if (c >= cols) begin
            c = 0;
            r++;
        end
        if (r < rows) begin
            row_pos = r;
            col_pos = c;
            return;
        end

        // walk back from the bottom-right corner
        tr = rows - 1;
        tc = cols - 1;
        while (tr != 0 || tc != 0) begin
            if (tc == 0)
                dir = MOVE_DOWN;
            else if (tr == 0)
                dir = MOVE_RIGHT;
            else
                dir = came_from_above[tr * DEF_MAX_COLS + tc];
            moves.push_front(dir);
            if (dir == MOVE_DOWN)
                tr--;
            else
                tc--;
        end

        res.kind  = KIND_TOTAL;
        res.move  = MOVE_RIGHT;
        res.total = t_sum'(s);
        res.last  = (moves.size() == 0);
        pending_results = {pending_results, res};
        foreach (moves[i]) begin
            res.kind  = KIND_MOVE;
            res.move  = moves[i];
            res.total = '0;
            res.last  = (i == moves.size() - 1);
            pending_results = {pending_results, res};
        end
        grids_done++;
        restart_grid();
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // result side: random stalls and checking of every transfer
    always @(posedge i_clk) begin : result_check
        path_result_t got;
        path_result_t want;
        if (!i_rst_n) begin
            stall_left = 0;
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got.kind  = res_if.result_kind;
                got.move  = res_if.move_down;
                got.total = res_if.total_cost;
                got.last  = res_if.last_result;
                results_seen++;
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display({"%0t: unexpected result, expected none, ",
                              "actual kind %0d move %0d total %0d last %0d"},
                             $time, got.kind, got.move, got.total, got.last);
                end else begin
                    want = pending_results.pop_front();
                    check_field("result_kind", want.kind, got.kind);
                    check_field("move_down", want.move, got.move);
                    check_field("total_cost", int'(want.total), int'(got.total));
                    check_field("last_result", want.last, got.last);
                end
                stall_left = receiver_idle_on ? $urandom_range(0, MAX_STALL) : 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            res_if.ready <= (stall_left == 0);
        end
    end

    task automatic apb_access(input logic wr, input logic idx, input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_dim(logic idx, t_dim want);
        logic [APB_DW-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== APB_DW'(want)) begin
            error_count++;
            $display("%0t: register %0d read mismatch, expected %0d, actual %0d",
                     $time, idx, want, rd);
        end
    endtask

    task automatic write_dim(logic idx, t_dim value);
        logic [APB_DW-1:0] wdata;
        logic [APB_DW-1:0] rd;
        // upper bits are noise and must be dropped
        wdata                = $urandom;
        wdata[DIM_BITS-1:0]  = value;
        apb_access(1'b1, idx, wdata, rd);
        if (idx == CFG_ROWS)
            rows_reg = value;
        else
            cols_reg = value;
        restart_grid();
        check_dim(idx, value);
    endtask

    task automatic set_grid(t_dim rows, t_dim cols);
        write_dim(CFG_ROWS, rows);
        write_dim(CFG_COLS, cols);
    endtask

    task automatic send_cell(t_cost cost);
        int gap;
        gap = sender_idle_on ? $urandom_range(0, MAX_STALL) : 0;
        if (gap > 0) begin
            cell_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cell_if.valid     <= 1'b1;
        cell_if.cell_cost <= cost;
        do @(posedge i_clk); while (!cell_if.ready);
        predict_cell(cost);
        cells_sent++;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic end_of_stream();
        cell_if.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_cost draw_cost(cost_mix_e mix);
        case (mix)
            COST_TIES: begin
                return t_cost'($urandom_range(0, 2));
            end
            COST_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       return COST_MIN;
                    1:       return COST_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: begin
                return t_cost'($urandom);
            end
        endcase
    endfunction

    task automatic send_random_cells(int count, cost_mix_e mix);
        repeat (count)
            send_cell(draw_cost(mix));
    endtask

    task automatic test_single_cell();
        check_dim(CFG_ROWS, 1);
        check_dim(CFG_COLS, 1);
        send_cell(COST_MIN);
        send_cell(COST_MAX);
        end_of_stream();
    endtask

    task automatic test_zero_dims();
        set_grid(0, 0);
        send_cell('0);
        send_cell('1);
        end_of_stream();
    endtask

    task automatic test_top_row();
        set_grid(1, 4);
        send_cell(COST_MAX);
        send_cell(COST_MIN);
        send_cell(t_cost'(16'h5555));
        send_cell(t_cost'(16'haaaa));
        end_of_stream();
    endtask

    task automatic test_left_column();
        set_grid(3, 1);
        send_cell(t_cost'(1));
        send_cell(COST_MIN);
        send_cell(COST_MAX);
        end_of_stream();
    endtask

    task automatic test_ties();
        set_grid(3, 3);
        repeat (9)
            send_cell('0);
        end_of_stream();
    endtask

    task automatic test_restart();
        set_grid(2, 2);
        send_cell(t_cost'(7));
        send_cell(t_cost'(-7));
        // abandon the grid half way, a write starts over at the top-left cell
        cell_if.valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_dim(CFG_COLS, 2);
        send_cell(COST_MAX);
        send_cell(COST_MIN);
        send_cell(COST_MAX);
        send_cell(COST_MAX);
        end_of_stream();
    endtask

    task automatic test_largest_grid();
        sender_idle_on   = $urandom_range(0, 1);
        receiver_idle_on = 1'b1;
        // oversize dimensions fall back to the maximum
        set_grid(63, 1);
        send_random_cells(DEF_MAX_ROWS, COST_FULL);
        end_of_stream();
        set_grid(1, 63);
        send_random_cells(DEF_MAX_COLS, COST_FULL);
        end_of_stream();
    endtask

    task automatic test_random_grids();
        int   start_cells;
        t_dim rows;
        t_dim cols;
        start_cells = cells_sent;
        while (cells_sent - start_cells < RANDOM_CELLS) begin
            rows = ($urandom_range(0, 9) == 0) ? t_dim'(0) : t_dim'($urandom_range(1, 4));
            cols = ($urandom_range(0, 9) == 0) ? t_dim'(0) : t_dim'($urandom_range(1, 4));
            sender_idle_on   = ($urandom_range(0, 3) != 0);
            receiver_idle_on = ($urandom_range(0, 3) != 0);
            set_grid(rows, cols);
            send_random_cells(clamp_dim(rows, DEF_MAX_ROWS) * clamp_dim(cols, DEF_MAX_COLS),
                              cost_mix_e'($urandom_range(0, 2)));
            end_of_stream();
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        cell_if.valid     <= 1'b0;
        cell_if.cell_cost <= '0;
        sender_idle_on    = 1'b1;
        receiver_idle_on  = 1'b1;
        rows_reg          = 1;
        cols_reg          = 1;
        restart_grid();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_cell();
        test_zero_dims();
        test_top_row();
        test_left_column();
        test_ties();
        test_restart();
        test_largest_grid();
        test_random_grids();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d grids of up to 32 rows or columns streamed, %0d cells in total",
                 grids_done, cells_sent);
        $display("%0d results checked, %0d mismatches", results_seen, error_count);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
